FILE: rtl/ray_obb_slab_intersect_unit_assert.svh
// Assertion macros for the ray versus oriented box unit; roi_merge uses them.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef RAY_OBB_SLAB_INTERSECT_UNIT_ASSERT_SVH
`define RAY_OBB_SLAB_INTERSECT_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define ROI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ROI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/roi_pkg.sv
package roi_pkg;

  localparam int CW         = 16;
  localparam int REG_W      = 48;
  localparam int EPS_W      = 16;
  localparam int IDX_W      = 3;
  localparam int REL_W      = CW + 1;
  localparam int OP_W       = REL_W + CW + 2;
  localparam int DP_W       = 2 * CW + 2;
  localparam int EXT_W      = CW + 14;
  localparam int SN_W       = OP_W + 2;
  localparam int MAG_W      = 34;
  localparam int NUM_W      = MAG_W + 16;
  localparam int DEN_W      = 32;
  localparam int T_W        = 52;
  localparam int DIV_STAGES = NUM_W;
  localparam int LANE_LAT   = DIV_STAGES + 3;
  localparam int TA_W       = 41;
  localparam int PROD_W     = TA_W + 1 + CW;
  localparam int SAT_IN_W   = 60;
  localparam int OUT_W      = 32;

  localparam logic signed [T_W-1:0] T_BIG = 52'sd655360000000000;
  localparam logic [TA_W-1:0]       T_CAP = 41'd1099511627776;

  localparam logic [IDX_W-1:0] REG_CENTER  = 3'd0;
  localparam logic [IDX_W-1:0] REG_AXIS_0  = 3'd1;
  localparam logic [IDX_W-1:0] REG_AXIS_1  = 3'd2;
  localparam logic [IDX_W-1:0] REG_AXIS_2  = 3'd3;
  localparam logic [IDX_W-1:0] REG_EXTENTS = 3'd4;
  localparam logic [IDX_W-1:0] REG_EPSILON = 3'd5;

  localparam logic [REG_W-1:0] RST_CENTER  = 48'd0;
  localparam logic [REG_W-1:0] RST_AXIS_0  = 48'd16384;
  localparam logic [REG_W-1:0] RST_AXIS_1  = 48'd1073741824;
  localparam logic [REG_W-1:0] RST_AXIS_2  = 48'd70368744177664;
  localparam logic [REG_W-1:0] RST_EXTENTS = 48'd1099528405248;
  localparam logic [EPS_W-1:0] RST_EPSILON = 16'd419;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic                    hit;
    logic                    result_written;
    logic signed [OUT_W-1:0] distance;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
    logic signed [OUT_W-1:0] point_z;
  } result_t;

  // What one lane reports about its slab.
  typedef struct packed {
    logic                  par;
    logic                  pmiss;
    logic signed [T_W-1:0] t_lo;
    logic signed [T_W-1:0] t_hi;
  } slab_t;

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAT_IN_W-1:0] hi;
    logic signed [SAT_IN_W-1:0] lo;
    hi = SAT_IN_W'(32'sh7fffffff);
    lo = SAT_IN_W'(-33'sd2147483648);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

FILE: rtl/roi_div.sv
module roi_div import roi_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
    logic [DEN_W-1:0] den;
  } stage_t;

  // One restoring step: bring down the next numerator bit and try the subtract.
  function automatic stage_t step(input stage_t s);
    logic [DEN_W:0] r2;
    logic           ge;
    stage_t         o;
    r2    = {s.rem, s.num[NUM_W-1]};
    ge    = r2 >= {1'b0, s.den};
    o.rem = ge ? DEN_W'(r2 - {1'b0, s.den}) : r2[DEN_W-1:0];
    o.num = s.num << 1;
    o.quo = {s.quo[NUM_W-2:0], ge};
    o.den = s.den;
    return o;
  endfunction

  stage_t st [DIV_STAGES];
  stage_t init;

  always_comb begin
    init.rem = '0;
    init.num = num;
    init.quo = '0;
    init.den = den;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= step(init);
      for (int k = 1; k < DIV_STAGES; k++) begin
        st[k] <= step(st[k-1]);
      end
    end
  end

  assign quo = st[DIV_STAGES-1].quo;

endmodule

FILE: rtl/roi_lane.sv
module roi_lane import roi_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [REL_W-1:0] rel [3],
  input  logic signed [CW-1:0]    dir [3],
  input  logic [REG_W-1:0]        axis,
  input  logic signed [CW-1:0]    extent,
  input  logic [EPS_W-1:0]        eps,
  output slab_t                   slab
);

  typedef struct packed {
    logic par;
    logic pmiss;
    logic neg1;
    logic neg2;
  } side_t;

  logic signed [CW-1:0]       ax [3];
  logic signed [REL_W+CW-1:0] op_prod [3];
  logic signed [2*CW-1:0]     dp_prod [3];
  logic signed [EXT_W-1:0]    ext_a;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax[k] = axis[k*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        op_prod[k] <= rel[k] * ax[k];
        dp_prod[k] <= dir[k] * ax[k];
      end
      ext_a <= EXT_W'(extent) <<< 14;
    end
  end

  logic signed [OP_W-1:0] op;
  logic signed [OP_W-1:0] ext_o;
  logic signed [DP_W-1:0] dp;
  logic [DP_W-1:0]        adp;
  logic signed [SN_W-1:0] sn1, sn2, m1, m2;
  side_t                  side_b;

  always_comb begin
    op = OP_W'(op_prod[0]) + OP_W'(op_prod[1]) + OP_W'(op_prod[2]);
    dp = DP_W'(dp_prod[0]) + DP_W'(dp_prod[1]) + DP_W'(dp_prod[2]);
    ext_o = OP_W'(ext_a);
    adp = dp[DP_W-1] ? DP_W'(-dp) : DP_W'(dp);
    side_b.par = (adp < DP_W'(eps)) || (dp == '0);
    side_b.pmiss = side_b.par && ((op < -ext_o) || (op > ext_o));
    sn1 = -SN_W'(ext_a) - SN_W'(op);
    sn2 = SN_W'(ext_a) - SN_W'(op);
    m1 = sn1[SN_W-1] ? -sn1 : sn1;
    m2 = sn2[SN_W-1] ? -sn2 : sn2;
    side_b.neg1 = sn1[SN_W-1] ^ dp[DP_W-1];
    side_b.neg2 = sn2[SN_W-1] ^ dp[DP_W-1];
  end

  logic [NUM_W-1:0] num1, num2, q1, q2;
  logic [DEN_W-1:0] den;
  side_t            side_r;
  side_t            sd [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      num1   <= {m1[MAG_W-1:0], 16'b0};
      num2   <= {m2[MAG_W-1:0], 16'b0};
      den    <= adp[DEN_W-1:0];
      side_r <= side_b;
      sd[0]  <= side_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  roi_div u_div1 (.clk(clk), .en(en), .num(num1), .den(den), .quo(q1));
  roi_div u_div2 (.clk(clk), .en(en), .num(num2), .den(den), .quo(q2));

  logic signed [T_W-1:0] t1, t2;
  side_t                 sd_o;

  always_comb begin
    sd_o = sd[DIV_STAGES-1];
    t1 = signed'(T_W'(q1));
    t2 = signed'(T_W'(q2));
    if (sd_o.neg1) begin
      t1 = -t1;
    end
    if (sd_o.neg2) begin
      t2 = -t2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slab.par   <= sd_o.par;
      slab.pmiss <= sd_o.pmiss;
      slab.t_lo  <= (t1 > t2) ? t2 : t1;
      slab.t_hi  <= (t1 > t2) ? t1 : t2;
    end
  end

endmodule

FILE: rtl/roi_merge.sv
`include "ray_obb_slab_intersect_unit_assert.svh"
module roi_merge import roi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  slab_t                slab [3],
  input  logic signed [CW-1:0] org [3],
  input  logic signed [CW-1:0] dir [3],
  output logic                 out_valid,
  output result_t              out
);

  logic signed [T_W-1:0] near, far, anear;
  logic                  miss, hit;
  logic [TA_W-1:0]       ta;

  // The interval only narrows, so an empty interval at any axis is the same
  // as an empty interval after all three.
  always_comb begin
    near = -T_BIG;
    far  = T_BIG;
    miss = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (slab[k].par) begin
        miss = miss | slab[k].pmiss;
      end else begin
        if (slab[k].t_lo > near) begin
          near = slab[k].t_lo;
        end
        if (slab[k].t_hi < far) begin
          far = slab[k].t_hi;
        end
      end
    end
    miss  = miss | (near > far);
    hit   = !near[T_W-1] || !far[T_W-1];
    anear = near[T_W-1] ? -near : near;
    ta    = (anear > signed'(T_W'(T_CAP))) ? T_CAP : anear[TA_W-1:0];
  end

  logic                    m1_valid, m1_miss, m1_hit;
  logic signed [OUT_W-1:0] m1_dist;
  logic [TA_W-1:0]         m1_ta;
  logic signed [CW-1:0]    m1_org [3];
  logic signed [CW-1:0]    m1_dir [3];

  logic                    m2_valid, m2_miss, m2_hit;
  logic signed [OUT_W-1:0] m2_dist;
  logic signed [PROD_W-1:0] m2_prod [3];
  logic signed [CW-1:0]    m2_org [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid  <= 1'b0;
      m2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m1_valid  <= in_valid;
      m2_valid  <= m1_valid;
      out_valid <= m2_valid;
    end
  end

  logic signed [TA_W:0]       ta_s;
  logic signed [PROD_W-1:0]   pb [3];
  logic signed [PROD_W-1:0]   q [3];
  logic signed [SAT_IN_W-1:0] sum [3];
  logic signed [OUT_W-1:0]    pt [3];

  always_comb begin
    ta_s = signed'({1'b0, m1_ta});
    for (int k = 0; k < 3; k++) begin
      pb[k]  = m2_prod[k][PROD_W-1] ? m2_prod[k] + PROD_W'(255) : m2_prod[k];
      q[k]   = pb[k] >>> 8;
      sum[k] = (SAT_IN_W'(m2_org[k]) <<< 8) + SAT_IN_W'(q[k]);
      pt[k]  = sat32(sum[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_miss <= miss;
      m1_hit  <= hit;
      m1_dist <= sat32(SAT_IN_W'(near));
      m1_ta   <= ta;
      m1_org  <= org;
      m1_dir  <= dir;
      m2_miss <= m1_miss;
      m2_hit  <= m1_hit;
      m2_dist <= m1_dist;
      m2_org  <= m1_org;
      for (int k = 0; k < 3; k++) begin
        m2_prod[k] <= ta_s * m1_dir[k];
      end
      if (m2_miss) begin
        out <= '0;
      end else begin
        out.hit            <= m2_hit;
        out.result_written <= 1'b1;
        out.distance       <= m2_dist;
        out.point_x        <= pt[0];
        out.point_y        <= pt[1];
        out.point_z        <= pt[2];
      end
    end
  end

  `ROI_ASSERT(a_miss_clear, out_valid && !out.result_written |-> !out.hit && out.distance == 0 && out.point_x == 0, "early miss left data in the result")
  `ROI_ASSERT(a_ahead_hits, out_valid && out.result_written && !out.distance[OUT_W-1] |-> out.hit, "nonnegative distance without hit")
  `ROI_ASSERT_NEXT(a_advance, en && m2_valid, out_valid, "result lost in the last stage")

endmodule

FILE: rtl/ray_obb_slab_intersect_unit.sv
// Ray versus oriented box slab test. One ray enters per cycle and passes one
// input register, three slab lanes (one per box axis), each with the two
// 50-stage pipelined restoring dividers that produce the entry and exit
// distances, and three merge stages that narrow the interval, scale the
// direction and saturate the point. The whole pipeline, input included, holds
// while a finished result is stalled. The user must write the box through the
// cfg port (center, three axes, extents, parallel threshold) only while no
// ray is in flight; the block does not enforce this. cfg_ready is always high.
module ray_obb_slab_intersect_unit import roi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             ray_valid,
  output logic             ray_stall,
  input  ray_t             ray,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  logic [REG_W-1:0] box_center, box_axis_0, box_axis_1, box_axis_2, box_extents;
  logic [EPS_W-1:0] parallel_epsilon;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_center       <= RST_CENTER;
      box_axis_0       <= RST_AXIS_0;
      box_axis_1       <= RST_AXIS_1;
      box_axis_2       <= RST_AXIS_2;
      box_extents      <= RST_EXTENTS;
      parallel_epsilon <= RST_EPSILON;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER:  box_center       <= cfg_data;
        REG_AXIS_0:  box_axis_0       <= cfg_data;
        REG_AXIS_1:  box_axis_1       <= cfg_data;
        REG_AXIS_2:  box_axis_2       <= cfg_data;
        REG_EXTENTS: box_extents      <= cfg_data;
        REG_EPSILON: parallel_epsilon <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en        = !(result_valid && result_stall);
  assign ray_stall = !en;

  logic                    s0_valid;
  ray_t                    s0_ray;
  logic signed [REL_W-1:0] rel [3];
  logic signed [CW-1:0]    in_org [3];
  logic signed [CW-1:0]    ctr [3];
  logic signed [CW-1:0]    s0_dir [3];

  always_comb begin
    in_org[0] = ray.origin_x;
    in_org[1] = ray.origin_y;
    in_org[2] = ray.origin_z;
    s0_dir[0] = s0_ray.dir_x;
    s0_dir[1] = s0_ray.dir_y;
    s0_dir[2] = s0_ray.dir_z;
    for (int k = 0; k < 3; k++) begin
      ctr[k] = box_center[k*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= ray_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ray <= ray;
      for (int k = 0; k < 3; k++) begin
        rel[k] <= REL_W'(in_org[k]) - REL_W'(ctr[k]);
      end
    end
  end

  logic [REG_W-1:0] axes [3];
  slab_t            slab [3];

  always_comb begin
    axes[0] = box_axis_0;
    axes[1] = box_axis_1;
    axes[2] = box_axis_2;
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    roi_lane u_lane (
      .clk    (clk),
      .en     (en),
      .rel    (rel),
      .dir    (s0_dir),
      .axis   (axes[i]),
      .extent (box_extents[i*CW +: CW]),
      .eps    (parallel_epsilon),
      .slab   (slab[i])
    );
  end

  // The ray itself rides alongside the lanes to the merge stages.
  logic [LANE_LAT-1:0] vld_dl;
  ray_t                ray_dl [LANE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_dl <= '0;
    end else if (en) begin
      vld_dl <= {vld_dl[LANE_LAT-2:0], s0_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray_dl[0] <= s0_ray;
      for (int k = 1; k < LANE_LAT; k++) begin
        ray_dl[k] <= ray_dl[k-1];
      end
    end
  end

  logic signed [CW-1:0] m_org [3];
  logic signed [CW-1:0] m_dir [3];

  always_comb begin
    m_org[0] = ray_dl[LANE_LAT-1].origin_x;
    m_org[1] = ray_dl[LANE_LAT-1].origin_y;
    m_org[2] = ray_dl[LANE_LAT-1].origin_z;
    m_dir[0] = ray_dl[LANE_LAT-1].dir_x;
    m_dir[1] = ray_dl[LANE_LAT-1].dir_y;
    m_dir[2] = ray_dl[LANE_LAT-1].dir_z;
  end

  roi_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld_dl[LANE_LAT-1]),
    .slab      (slab),
    .org       (m_org),
    .dir       (m_dir),
    .out_valid (result_valid),
    .out       (result)
  );

endmodule
